>>> design/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg: shared definitions for the fractional complex resampler
// Widths, fixed-point constants, sequencer states and the result item type.
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 16;   // phase / step fraction
    localparam int GAIN_FRAC_BITS = 16;
    localparam int MAX_UPSAMPLE   = 16;
    localparam int MAX_DOWNSAMPLE = 256;

    localparam int STEP_W  = 25;
    localparam int GAIN_W  = 17;
    localparam int PHASE_W = 24;
    localparam int ACC_W   = 40;

    // shared multiplier: signed A by unsigned B
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = 38;

    // gain scaling splits the window sum into a low and a high chunk
    localparam int LO_W   = 20;
    localparam int SUM_W  = LO_W + MUL_A_W;
    localparam int PLO_W  = LO_W + GAIN_W;
    localparam int TOT_W  = MUL_P_W + LO_W + 1;
    localparam int SCL_SH = FRAC_BITS + GAIN_FRAC_BITS;
    localparam int SCL_W  = TOT_W - SCL_SH;

    localparam logic [STEP_W-1:0]  STEP_ONE = STEP_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_LO  =
        STEP_W'(((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);
    localparam logic [STEP_W-1:0]  STEP_HI  = STEP_W'(MAX_DOWNSAMPLE) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] PH_ONE   = PHASE_W'(1) << FRAC_BITS;
    localparam logic [GAIN_W-1:0]  GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [MUL_P_W-1:0] IP_HALF  = MUL_P_W'(1) << (FRAC_BITS - 1);
    localparam logic [TOT_W-1:0]   TOT_HALF = TOT_W'(1) << (SCL_SH - 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b1;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_UP,
        MODE_DOWN
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UCHK,
        S_UMUL,
        S_URES,
        S_DCHK,
        S_DSEL,
        S_DMUL,
        S_DSUM,
        S_DS0,
        S_DS1,
        S_DS2,
        S_DS3,
        S_EMIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] out_i;
        logic [SAMPLE_BITS-1:0] out_q;
        logic                   run_last;
        logic                   frame_done;
    } t_res;

endpackage

>>> design/fcr_mul.sv
// ----------------------------------------------------------------------------
// fcr_mul: shared multiplier
// Signed by unsigned product with a registered output; holds while disabled.
// ----------------------------------------------------------------------------
module fcr_mul (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [fcr_pkg::MUL_A_W-1:0]  i_a,
    input  logic        [fcr_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [fcr_pkg::MUL_P_W-1:0]  o_p
);

    logic signed [fcr_pkg::MUL_A_W+fcr_pkg::MUL_B_W:0] w_full;
    logic signed [fcr_pkg::MUL_P_W-1:0]                r_p;

    assign w_full = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_full[fcr_pkg::MUL_P_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

>>> design/fcr_oreg.sv
// ----------------------------------------------------------------------------
// fcr_oreg: output register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module fcr_oreg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  fcr_pkg::t_res i_data,
    input  logic          i_stall,
    output logic          o_valid,
    output fcr_pkg::t_res o_data,
    output logic          o_free
);

    logic          r_valid;
    fcr_pkg::t_res r_data;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

>>> design/fractional_complex_resampler.sv
// ----------------------------------------------------------------------------
// fractional_complex_resampler: I/Q resampler by a fractional ratio
// Linear interpolation when upsampling, weighted box integration and gain
// when downsampling, pass-through at a ratio of one. One shared multiplier.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     i_valid / o_stall       i_in_i, i_in_q, i_frame_last
//  output    o_valid / i_stall       o_out_i, o_out_q, o_run_last, o_frame_done
//  config    i_cfg_we                i_cfg_idx, i_cfg_data
//
//  One item at a time; o_stall is high from acceptance until the item is done.
//  Pass-through forwards the sample unchanged. Upsampling interpolates I and
//  then Q for each result; downsampling, when a window closes, has I and Q
//  each take the multiplier for one weighting and two gain partial products.
//  While o_valid is stalled with a result pending, the sequencer waits.
//  Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module fractional_complex_resampler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [fcr_pkg::SAMPLE_BITS-1:0] i_in_i,
    input  logic signed [fcr_pkg::SAMPLE_BITS-1:0] i_in_q,
    input  logic                                  i_frame_last,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [fcr_pkg::SAMPLE_BITS-1:0] o_out_i,
    output logic signed [fcr_pkg::SAMPLE_BITS-1:0] o_out_q,
    output logic                                  o_run_last,
    output logic                                  o_frame_done,
    input  logic                                  i_cfg_we,
    input  logic [fcr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [fcr_pkg::STEP_W-1:0]            i_cfg_data
);

    localparam int SB = fcr_pkg::SAMPLE_BITS;
    localparam int FB = fcr_pkg::FRAC_BITS;

    fcr_pkg::t_state r_state, n_state;
    fcr_pkg::t_mode  r_mode;

    logic [fcr_pkg::STEP_W-1:0]  r_step_cfg;
    logic [fcr_pkg::GAIN_W-1:0]  r_gain;
    logic [fcr_pkg::STEP_W-1:0]  r_step;
    logic [fcr_pkg::STEP_W-1:0]  r_rem;
    logic [fcr_pkg::PHASE_W-1:0] r_ph;
    logic [fcr_pkg::PHASE_W-1:0] r_next_phase;
    logic                        r_phb;
    logic                        r_chan;
    logic                        r_last;
    logic                        r_have_prev;
    logic [SB-1:0]               r_xi, r_xq, r_prev_i, r_prev_q, r_res_i, r_res_q;
    logic [fcr_pkg::ACC_W-1:0]   r_acc_i, r_acc_q;
    logic [fcr_pkg::SUM_W-1:0]   r_sum;
    logic [fcr_pkg::PLO_W-1:0]   r_plo;
    logic [fcr_pkg::TOT_W-1:0]   r_tot;

    logic                        w_accept;
    logic [fcr_pkg::STEP_W-1:0]  w_step_cl;
    logic [fcr_pkg::STEP_W-1:0]  w_rem;
    logic [fcr_pkg::STEP_W-1:0]  w_ph_nxt;
    logic [SB-1:0]               w_x, w_prev, w_ia, w_ib;
    logic [SB:0]                 w_d;
    logic [fcr_pkg::ACC_W-1:0]   w_acc, w_xs, w_acc_new;
    logic [fcr_pkg::SUM_W-1:0]   w_sum;
    logic [fcr_pkg::MUL_P_W-1:0] w_rnd;
    logic [fcr_pkg::MUL_P_W-FB-1:0] w_ip_full;
    logic [fcr_pkg::TOT_W-1:0]   w_tot;
    logic [fcr_pkg::SCL_W-1:0]   w_scl;
    logic [SB-1:0]               w_sat;
    logic                        w_fits;

    logic                               w_mul_en;
    logic signed [fcr_pkg::MUL_A_W-1:0] w_mul_a;
    logic        [fcr_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [fcr_pkg::MUL_P_W-1:0] w_p;

    logic          w_load, w_free, w_run_last;
    fcr_pkg::t_res w_res, w_odata;

    fcr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    fcr_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (w_odata),
        .o_free  (w_free)
    );

    assign o_out_i      = w_odata.out_i;
    assign o_out_q      = w_odata.out_q;
    assign o_run_last   = w_odata.run_last;
    assign o_frame_done = w_odata.frame_done;

    assign o_stall  = (r_state != fcr_pkg::S_IDLE);
    assign w_accept = i_valid && (r_state == fcr_pkg::S_IDLE);

    // ratio clamped to the supported range
    assign w_step_cl = (r_step_cfg < fcr_pkg::STEP_LO) ? fcr_pkg::STEP_LO :
                       (r_step_cfg > fcr_pkg::STEP_HI) ? fcr_pkg::STEP_HI : r_step_cfg;

    // uncovered part of the current downsampling window
    assign w_rem = ({1'b0, r_next_phase} < r_step) ? (r_step - {1'b0, r_next_phase}) : '0;

    assign w_ph_nxt = {1'b0, r_ph} + r_step;

    assign w_x    = r_chan ? r_xq : r_xi;
    assign w_prev = r_chan ? r_prev_q : r_prev_i;
    assign w_acc  = r_chan ? r_acc_q : r_acc_i;

    // interpolation ends: prev -> x, or x -> 0 past the frame's last sample
    assign w_ia = r_phb ? w_x : w_prev;
    assign w_ib = r_phb ? '0 : w_x;
    assign w_d  = {w_ib[SB-1], w_ib} - {w_ia[SB-1], w_ia};

    assign w_rnd     = w_p + fcr_pkg::IP_HALF;
    assign w_ip_full = w_rnd[fcr_pkg::MUL_P_W-1:FB]
                     + {{(fcr_pkg::MUL_P_W-FB-SB){w_ia[SB-1]}}, w_ia};

    assign w_xs      = {{(fcr_pkg::ACC_W-SB-FB){w_x[SB-1]}}, w_x, {FB{1'b0}}};
    assign w_sum     = {{(fcr_pkg::SUM_W-fcr_pkg::ACC_W){w_acc[fcr_pkg::ACC_W-1]}}, w_acc}
                     + {{(fcr_pkg::SUM_W-fcr_pkg::MUL_P_W){w_p[fcr_pkg::MUL_P_W-1]}}, w_p};
    assign w_acc_new = w_xs
                     - {{(fcr_pkg::ACC_W-fcr_pkg::MUL_P_W){w_p[fcr_pkg::MUL_P_W-1]}}, w_p};

    // high partial product shifted over the low one, plus rounding half
    assign w_tot = {{(fcr_pkg::TOT_W-fcr_pkg::MUL_P_W-fcr_pkg::LO_W){w_p[fcr_pkg::MUL_P_W-1]}},
                    w_p, {fcr_pkg::LO_W{1'b0}}}
                 + {{(fcr_pkg::TOT_W-fcr_pkg::PLO_W){1'b0}}, r_plo}
                 + fcr_pkg::TOT_HALF;

    assign w_scl  = r_tot[fcr_pkg::TOT_W-1:fcr_pkg::SCL_SH];
    assign w_fits = (&w_scl[fcr_pkg::SCL_W-1:SB-1]) || !(|w_scl[fcr_pkg::SCL_W-1:SB-1]);
    assign w_sat  = w_fits ? w_scl[SB-1:0] :
                    (w_scl[fcr_pkg::SCL_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});

    // last result of the item: no further output position before the sample
    // (or the frame) runs out
    always_comb begin
        case (r_mode)
            fcr_pkg::MODE_UP: begin
                if (r_phb) begin
                    w_run_last = ({1'b0, w_ph_nxt} >= {1'b0, fcr_pkg::STEP_ONE});
                end else begin
                    w_run_last = (w_ph_nxt >= fcr_pkg::STEP_ONE) && !r_last;
                end
            end
            default: w_run_last = 1'b1;
        endcase
    end

    assign w_res.out_i      = r_res_i;
    assign w_res.out_q      = r_res_q;
    assign w_res.run_last   = w_run_last;
    assign w_res.frame_done = w_run_last && r_last;

    always_comb begin
        n_state  = r_state;
        w_mul_en = 1'b0;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_load   = 1'b0;
        case (r_state)
            fcr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (w_step_cl == fcr_pkg::STEP_ONE) begin
                        n_state = fcr_pkg::S_EMIT;
                    end else if (w_step_cl < fcr_pkg::STEP_ONE) begin
                        n_state = fcr_pkg::S_UCHK;
                    end else begin
                        n_state = fcr_pkg::S_DCHK;
                    end
                end
            end
            fcr_pkg::S_UCHK: begin
                if (!r_phb) begin
                    if (r_ph < fcr_pkg::PH_ONE) begin
                        n_state = fcr_pkg::S_UMUL;
                    end else if (!r_last) begin
                        n_state = fcr_pkg::S_FIN;
                    end
                end else if (r_last && (r_ph < fcr_pkg::PH_ONE)) begin
                    n_state = fcr_pkg::S_UMUL;
                end else begin
                    n_state = fcr_pkg::S_FIN;
                end
            end
            fcr_pkg::S_UMUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = {{(fcr_pkg::MUL_A_W-SB-1){w_d[SB]}}, w_d};
                w_mul_b  = {{(fcr_pkg::MUL_B_W-FB){1'b0}}, r_ph[FB-1:0]};
                n_state  = fcr_pkg::S_URES;
            end
            fcr_pkg::S_URES: begin
                n_state = r_chan ? fcr_pkg::S_EMIT : fcr_pkg::S_UMUL;
            end
            fcr_pkg::S_DCHK: n_state = fcr_pkg::S_DSEL;
            fcr_pkg::S_DSEL: begin
                if (r_rem > fcr_pkg::STEP_ONE) begin
                    n_state = fcr_pkg::S_FIN;
                end else begin
                    n_state = fcr_pkg::S_DMUL;
                end
            end
            fcr_pkg::S_DMUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = {{(fcr_pkg::MUL_A_W-SB){w_x[SB-1]}}, w_x};
                w_mul_b  = r_rem[fcr_pkg::MUL_B_W-1:0];
                n_state  = fcr_pkg::S_DSUM;
            end
            fcr_pkg::S_DSUM: n_state = fcr_pkg::S_DS0;
            fcr_pkg::S_DS0: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_sum[fcr_pkg::LO_W-1:0]};
                w_mul_b  = r_gain;
                n_state  = fcr_pkg::S_DS1;
            end
            fcr_pkg::S_DS1: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_sum[fcr_pkg::SUM_W-1:fcr_pkg::LO_W];
                w_mul_b  = r_gain;
                n_state  = fcr_pkg::S_DS2;
            end
            fcr_pkg::S_DS2: n_state = fcr_pkg::S_DS3;
            fcr_pkg::S_DS3: begin
                n_state = r_chan ? fcr_pkg::S_EMIT : fcr_pkg::S_DMUL;
            end
            fcr_pkg::S_EMIT: begin
                if (w_free) begin
                    w_load  = 1'b1;
                    n_state = (r_mode == fcr_pkg::MODE_UP) ? fcr_pkg::S_UCHK : fcr_pkg::S_FIN;
                end
            end
            fcr_pkg::S_FIN: n_state = fcr_pkg::S_IDLE;
            default:        n_state = fcr_pkg::S_IDLE;
        endcase
    end

    // control and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fcr_pkg::S_IDLE;
            r_mode       <= fcr_pkg::MODE_PASS;
            r_step_cfg   <= fcr_pkg::STEP_ONE;
            r_gain       <= fcr_pkg::GAIN_ONE;
            r_have_prev  <= 1'b0;
            r_next_phase <= '0;
            r_acc_i      <= '0;
            r_acc_q      <= '0;
            r_prev_i     <= '0;
            r_prev_q     <= '0;
            r_chan       <= 1'b0;
            r_phb        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fcr_pkg::CFG_STEP: r_step_cfg <= i_cfg_data;
                    fcr_pkg::CFG_GAIN: r_gain     <= i_cfg_data[fcr_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                fcr_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_chan <= 1'b0;
                        if (w_step_cl == fcr_pkg::STEP_ONE) begin
                            r_mode <= fcr_pkg::MODE_PASS;
                        end else if (w_step_cl < fcr_pkg::STEP_ONE) begin
                            r_mode <= fcr_pkg::MODE_UP;
                            r_phb  <= !r_have_prev;
                            if (!r_have_prev) begin
                                r_prev_i    <= i_in_i;
                                r_prev_q    <= i_in_q;
                                r_have_prev <= 1'b1;
                            end
                        end else begin
                            r_mode <= fcr_pkg::MODE_DOWN;
                        end
                    end
                end
                fcr_pkg::S_UCHK: begin
                    // leaving the prev -> x span: x becomes the previous sample
                    if (!r_phb && (r_ph >= fcr_pkg::PH_ONE)) begin
                        r_prev_i    <= r_xi;
                        r_prev_q    <= r_xq;
                        r_have_prev <= 1'b1;
                        r_phb       <= 1'b1;
                    end
                end
                fcr_pkg::S_URES: r_chan <= !r_chan;
                fcr_pkg::S_DCHK: r_have_prev <= 1'b1;
                fcr_pkg::S_DSEL: begin
                    if (r_rem > fcr_pkg::STEP_ONE) begin
                        r_acc_i      <= r_acc_i + {{(fcr_pkg::ACC_W-SB-FB){r_xi[SB-1]}},
                                                   r_xi, {FB{1'b0}}};
                        r_acc_q      <= r_acc_q + {{(fcr_pkg::ACC_W-SB-FB){r_xq[SB-1]}},
                                                   r_xq, {FB{1'b0}}};
                        r_next_phase <= r_next_phase + fcr_pkg::PH_ONE;
                    end else begin
                        r_next_phase <= fcr_pkg::PH_ONE - r_rem[fcr_pkg::PHASE_W-1:0];
                    end
                end
                fcr_pkg::S_DSUM: begin
                    if (r_chan) begin
                        r_acc_q <= w_acc_new;
                    end else begin
                        r_acc_i <= w_acc_new;
                    end
                end
                fcr_pkg::S_DS3: r_chan <= !r_chan;
                fcr_pkg::S_FIN: begin
                    if (r_last) begin
                        r_have_prev  <= 1'b0;
                        r_next_phase <= '0;
                        r_acc_i      <= '0;
                        r_acc_q      <= '0;
                        r_prev_i     <= '0;
                        r_prev_q     <= '0;
                    end else if (r_mode == fcr_pkg::MODE_UP) begin
                        r_next_phase <= r_ph;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers of the item in flight
    always_ff @(posedge i_clk) begin
        case (r_state)
            fcr_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_xi    <= i_in_i;
                    r_xq    <= i_in_q;
                    r_last  <= i_frame_last;
                    r_step  <= w_step_cl;
                    r_res_i <= i_in_i;
                    r_res_q <= i_in_q;
                    r_ph    <= r_have_prev ? r_next_phase : '0;
                end
            end
            fcr_pkg::S_UCHK: begin
                if (!r_phb && (r_ph >= fcr_pkg::PH_ONE)) begin
                    r_ph <= r_ph - fcr_pkg::PH_ONE;
                end
            end
            fcr_pkg::S_URES: begin
                if (r_chan) begin
                    r_res_q <= w_ip_full[SB-1:0];
                end else begin
                    r_res_i <= w_ip_full[SB-1:0];
                end
            end
            fcr_pkg::S_DCHK: r_rem <= w_rem;
            fcr_pkg::S_DSUM: r_sum <= w_sum;
            fcr_pkg::S_DS1:  r_plo <= w_p[fcr_pkg::PLO_W-1:0];
            fcr_pkg::S_DS2:  r_tot <= w_tot;
            fcr_pkg::S_DS3: begin
                if (r_chan) begin
                    r_res_q <= w_sat;
                end else begin
                    r_res_i <= w_sat;
                end
            end
            fcr_pkg::S_EMIT: begin
                if (w_free && (r_mode == fcr_pkg::MODE_UP)) begin
                    r_ph <= w_ph_nxt[fcr_pkg::PHASE_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

>>> dv/tb_fractional_complex_resampler.sv
// ----------------------------------------------------------------------------
// tb_fractional_complex_resampler: self-checking bench for the I/Q resampler
// Drives sample frames through pass-through, interpolating and integrating
// ratios, with register changes between frames and in mid-frame. Every output
// is compared against a bit-exact prediction kept alongside the bench, and
// both handshakes are idled and stalled at random.
// ----------------------------------------------------------------------------

class resampler_sb;
    logic [fcr_pkg::STEP_W-1:0]  step_reg;
    logic [fcr_pkg::GAIN_W-1:0]  gain_reg;
    longint                      prev_i, prev_q;
    longint                      acc_i, acc_q;
    bit                          have_prev;
    bit [fcr_pkg::PHASE_W-1:0]   next_phase;
    fcr_pkg::t_res               pending_out[$];
    fcr_pkg::t_res               burst[$];
    int                          failures;

    function new();
        step_reg = fcr_pkg::STEP_ONE;
        gain_reg = fcr_pkg::GAIN_ONE;
        failures = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        prev_i     = 0;
        prev_q     = 0;
        acc_i      = 0;
        acc_q      = 0;
        have_prev  = 1'b0;
        next_phase = '0;
    endfunction

    function void set_reg(logic [fcr_pkg::CFG_IDX_W-1:0] idx,
                          logic [fcr_pkg::STEP_W-1:0] data);
        if (idx == fcr_pkg::CFG_STEP)
            step_reg = data;
        else if (idx == fcr_pkg::CFG_GAIN)
            gain_reg = data[fcr_pkg::GAIN_W-1:0];
    endfunction

    function logic [fcr_pkg::SAMPLE_BITS-1:0] clip_sample(longint v);
        longint hi;
        hi = (64'sd1 <<< (fcr_pkg::SAMPLE_BITS - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return v[fcr_pkg::SAMPLE_BITS-1:0];
    endfunction

    // a*(1-ph) + b*ph, round half up
    function longint lerp(longint a, longint b, bit [31:0] ph);
        longint w, one_l;
        w     = longint'(ph);
        one_l = longint'(fcr_pkg::PH_ONE);
        return (a * (one_l - w) + b * w + (one_l >>> 1)) >>> fcr_pkg::FRAC_BITS;
    endfunction

    function longint gain_scale(longint acc);
        longint g;
        g = longint'(gain_reg);
        return (acc * g + (64'sd1 <<< (fcr_pkg::SCL_SH - 1))) >>> fcr_pkg::SCL_SH;
    endfunction

    function void push_out(longint vi, longint vq);
        fcr_pkg::t_res r;
        r.out_i      = clip_sample(vi);
        r.out_q      = clip_sample(vq);
        r.run_last   = 1'b0;
        r.frame_done = 1'b0;
        burst.push_back(r);
    endfunction

    // works out every output caused by one accepted sample
    function void take_sample(logic [fcr_pkg::SAMPLE_BITS-1:0] si,
                              logic [fcr_pkg::SAMPLE_BITS-1:0] sq, logic last);
        longint    xi, xq, one_l;
        bit [31:0] st, ph, rem, one_u;
        xi    = $signed(si);
        xq    = $signed(sq);
        one_u = 32'(fcr_pkg::PH_ONE);
        one_l = longint'(one_u);
        st    = 32'(step_reg);
        if (st < fcr_pkg::STEP_LO)
            st = 32'(fcr_pkg::STEP_LO);
        if (st > fcr_pkg::STEP_HI)
            st = 32'(fcr_pkg::STEP_HI);
        burst.delete();

        if (st == one_u) begin
            push_out(xi, xq);
        end else if (st < one_u) begin
            ph = 0;
            if (have_prev) begin
                ph = 32'(next_phase);
                while (ph < one_u) begin
                    push_out(lerp(prev_i, xi, ph), lerp(prev_q, xq, ph));
                    ph += st;
                end
                ph -= one_u;
            end
            prev_i    = xi;
            prev_q    = xq;
            have_prev = 1'b1;
            // flush: positions past the last sample fade toward zero
            if (last) begin
                while (ph < one_u) begin
                    push_out(lerp(xi, 0, ph), lerp(xq, 0, ph));
                    ph += st;
                end
            end
            next_phase = ph[fcr_pkg::PHASE_W-1:0];
        end else begin
            rem       = (32'(next_phase) < st) ? st - 32'(next_phase) : '0;
            have_prev = 1'b1;
            if (rem > one_u) begin
                acc_i      += xi * one_l;
                acc_q      += xq * one_l;
                next_phase += one_u[fcr_pkg::PHASE_W-1:0];
            end else begin
                acc_i += xi * longint'(rem);
                acc_q += xq * longint'(rem);
                push_out(gain_scale(acc_i), gain_scale(acc_q));
                acc_i      = xi * longint'(one_u - rem);
                acc_q      = xq * longint'(one_u - rem);
                next_phase = fcr_pkg::PHASE_W'(one_u - rem);
            end
        end

        if (burst.size() > 0) begin
            burst[burst.size()-1].run_last   = 1'b1;
            burst[burst.size()-1].frame_done = last;
        end
        foreach (burst[k])
            pending_out.push_back(burst[k]);
        if (last)
            clear_frame();
    endfunction

    function void check_output(fcr_pkg::t_res got);
        fcr_pkg::t_res want;
        if (pending_out.size() == 0) begin
            failures++;
            $display("%0t: output with none due: i=%0d q=%0d run_last=%0b frame_done=%0b",
                     $time, $signed(got.out_i), $signed(got.out_q), got.run_last,
                     got.frame_done);
            return;
        end
        want = pending_out.pop_front();
        if (got.out_i !== want.out_i || got.out_q !== want.out_q ||
            got.run_last !== want.run_last || got.frame_done !== want.frame_done) begin
            failures++;
            $display("%0t: mismatch exp i=%0d q=%0d rl=%0b fd=%0b got i=%0d q=%0d rl=%0b fd=%0b",
                     $time, $signed(want.out_i), $signed(want.out_q), want.run_last,
                     want.frame_done, $signed(got.out_i), $signed(got.out_q),
                     got.run_last, got.frame_done);
        end
    endfunction
endclass

module tb_fractional_complex_resampler;

    localparam int RST_CYCLES    = 8;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 200;

    localparam logic [fcr_pkg::SAMPLE_BITS-1:0] SMP_MAX =
        {1'b0, {(fcr_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam logic [fcr_pkg::SAMPLE_BITS-1:0] SMP_MIN =
        {1'b1, {(fcr_pkg::SAMPLE_BITS-1){1'b0}}};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [fcr_pkg::SAMPLE_BITS-1:0] i_in_i;
    logic [fcr_pkg::SAMPLE_BITS-1:0] i_in_q;
    logic                            i_frame_last;
    logic                            o_valid;
    logic                            i_stall;
    logic [fcr_pkg::SAMPLE_BITS-1:0] o_out_i;
    logic [fcr_pkg::SAMPLE_BITS-1:0] o_out_q;
    logic                            o_run_last;
    logic                            o_frame_done;
    logic                            i_cfg_we;
    logic [fcr_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [fcr_pkg::STEP_W-1:0]      i_cfg_data;

    resampler_sb sb;
    int          cycle_count  = 0;
    int          random_items = 0;
    bit          sender_burst = 1'b0;
    bit          hold_out_req = 1'b0;

    fractional_complex_resampler uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_i       (i_in_i),
        .i_in_q       (i_in_q),
        .i_frame_last (i_frame_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_i      (o_out_i),
        .o_out_q      (o_out_q),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("fractional_complex_resampler regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        fcr_pkg::t_res got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            got.out_i      = o_out_i;
            got.out_q      = o_out_q;
            got.run_last   = o_run_last;
            got.frame_done = o_frame_done;
            sb.check_output(got);
        end
    end

    // output side: segments of free flow, short stalls and rare long ones
    initial begin : out_sink
        int seg_left, seg_kind, busy;
        seg_left = 0;
        seg_kind = 0;
        busy     = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_out_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out_req = 1'b0;
                i_stall <= 1'b0;
            end else if (busy > 0) begin
                busy--;
            end else begin
                if (seg_left == 0) begin
                    seg_kind = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                if (seg_kind == 1 && $urandom_range(0, 9) < 3) begin
                    i_stall <= 1'b1;
                    busy = $urandom_range(0, 2);
                end else if (seg_kind == 2 && $urandom_range(0, 19) == 0) begin
                    i_stall <= 1'b1;
                    busy = $urandom_range(8, 40);
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (sender_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [fcr_pkg::SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return '0;
            default: return fcr_pkg::SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // valid stays up across back-to-back items; it only drops for a gap
    task automatic send_sample(input logic [fcr_pkg::SAMPLE_BITS-1:0] si,
                               input logic [fcr_pkg::SAMPLE_BITS-1:0] sq,
                               input logic last);
        int gap;
        i_valid      <= 1'b1;
        i_in_i       <= si;
        i_in_q       <= sq;
        i_frame_last <= last;
        do
            @(posedge i_clk);
        while (o_stall !== 1'b0);
        sb.take_sample(si, sq, last);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [fcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fcr_pkg::STEP_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // an item with no output may still be in flight once the queue drains
    task automatic settle();
        if (i_valid) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (sb.pending_out.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input bit squeeze);
        int                         kind, frames, len;
        bit                         open_end;
        logic [fcr_pkg::STEP_W-1:0] st;
        logic [fcr_pkg::STEP_W-1:0] g;
        kind = $urandom_range(0, 19);
        if (squeeze)
            st = fcr_pkg::STEP_W'($urandom_range(8192, 32768));
        else if (kind < 8)
            st = fcr_pkg::STEP_W'($urandom_range(fcr_pkg::STEP_LO, fcr_pkg::STEP_ONE - 1));
        else if (kind < 10)
            st = fcr_pkg::STEP_ONE;
        else if (kind < 15)
            st = fcr_pkg::STEP_W'($urandom_range(fcr_pkg::STEP_ONE + 1,
                                                 4 * fcr_pkg::STEP_ONE));
        else if (kind < 17)
            st = fcr_pkg::STEP_W'($urandom_range(4 * fcr_pkg::STEP_ONE,
                                                 16 * fcr_pkg::STEP_ONE));
        else if (kind == 17)
            st = fcr_pkg::STEP_W'($urandom_range(0, fcr_pkg::STEP_LO - 1));
        else if (kind == 18)
            st = fcr_pkg::STEP_W'($urandom_range(fcr_pkg::STEP_HI,
                                                 (1 << fcr_pkg::STEP_W) - 1));
        else
            st = ($urandom_range(0, 1) != 0) ? fcr_pkg::STEP_LO : fcr_pkg::STEP_HI;
        write_reg(fcr_pkg::CFG_STEP, st);

        if ($urandom_range(0, 1) != 0) begin
            kind = $urandom_range(0, 7);
            if (kind < 3)
                g = fcr_pkg::GAIN_ONE;
            else if (kind == 3)
                g = '0;
            else if (kind == 4)
                g = fcr_pkg::STEP_W'((1 << fcr_pkg::GAIN_W) - 1);
            else
                g = fcr_pkg::STEP_W'($urandom_range(0, (1 << fcr_pkg::GAIN_W) - 1));
            // bits above the gain width should be ignored
            if ($urandom_range(0, 3) == 0)
                g[fcr_pkg::STEP_W-1:fcr_pkg::GAIN_W] =
                    (fcr_pkg::STEP_W - fcr_pkg::GAIN_W)'($urandom);
            write_reg(fcr_pkg::CFG_GAIN, g);
        end

        sender_burst = ($urandom_range(0, 3) == 0);
        if (squeeze)
            hold_out_req = 1'b1;
        frames   = $urandom_range(1, 3);
        open_end = ($urandom_range(0, 6) == 0);
        for (int f = 0; f < frames; f++) begin
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
            for (int k = 0; k < len; k++)
                send_sample(pick_sample(), pick_sample(),
                            (k == len - 1) && !(open_end && f == frames - 1));
            random_items += len;
        end
        settle();
        sender_burst = 1'b0;
    endtask

    initial begin : main
        int phase_no;
        sb = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_in_i       <= '0;
        i_in_q       <= '0;
        i_frame_last <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= fcr_pkg::CFG_STEP;
        i_cfg_data   <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ratio one out of reset: straight through
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b0);
        send_sample('0, '1, 1'b1);
        settle();

        // finest step: full interpolation run plus flush, then a lone-sample frame
        write_reg(fcr_pkg::CFG_STEP, fcr_pkg::STEP_LO);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b1);
        send_sample(16'h1234, '1, 1'b1);
        settle();

        // zero step clamps to the finest one
        write_reg(fcr_pkg::CFG_STEP, '0);
        send_sample(SMP_MIN, SMP_MIN, 1'b0);
        send_sample(SMP_MAX, SMP_MAX, 1'b1);
        settle();

        // oversized step clamps to the widest window; partial window dropped
        write_reg(fcr_pkg::CFG_STEP, '1);
        write_reg(fcr_pkg::CFG_GAIN, fcr_pkg::STEP_W'((1 << fcr_pkg::GAIN_W) - 1));
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b1);
        settle();

        // step 1.5 with gain above unity: sums saturate
        write_reg(fcr_pkg::CFG_STEP, fcr_pkg::STEP_ONE + (fcr_pkg::STEP_ONE >> 1));
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b1);
        settle();

        write_reg(fcr_pkg::CFG_GAIN, '0);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b1);
        settle();

        // ratio switched mid-frame, up to down and back
        write_reg(fcr_pkg::CFG_GAIN, fcr_pkg::GAIN_ONE);
        write_reg(fcr_pkg::CFG_STEP, fcr_pkg::STEP_W'(21845));
        send_sample(16'd1000, -16'sd1000, 1'b0);
        send_sample(16'd2000, -16'sd2000, 1'b0);
        settle();
        write_reg(fcr_pkg::CFG_STEP, fcr_pkg::STEP_W'(5 * (fcr_pkg::STEP_ONE >> 1)));
        send_sample(16'd3000, -16'sd3000, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(-16'sd3000, 16'd3000, 1'b1);
        settle();
        write_reg(fcr_pkg::CFG_STEP, fcr_pkg::STEP_W'(3 * fcr_pkg::STEP_ONE));
        send_sample(SMP_MIN, SMP_MAX, 1'b0);
        send_sample(16'd500, 16'd700, 1'b0);
        settle();
        write_reg(fcr_pkg::CFG_STEP, fcr_pkg::STEP_W'(40000));
        send_sample(-16'sd500, SMP_MAX, 1'b0);
        send_sample(SMP_MAX, -16'sd700, 1'b1);
        settle();

        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            random_phase(phase_no == 2);
            phase_no++;
        end

        if (sb.failures == 0 && sb.pending_out.size() == 0)
            $display("fractional_complex_resampler regression: pass");
        else
            $display("fractional_complex_resampler regression: fail");
        $finish;
    end

endmodule
